### rtl/dfpih_pkg.sv
// Shared constants and saturation helpers for the DFP inverse-Hessian update block.
`timescale 1ns / 1ps

package dfpih_pkg;

	// Input item kinds
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	// Result status codes
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_ZERO = 2'd1;
	localparam logic [1:0] STAT_SAT  = 2'd2;

	// One in Q16.16
	localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;

	// Magnitude bits of a 32x32 product numerator, and divider step counter width
	localparam int QW  = 63;
	localparam int DCW = 6;

	// Clamp a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'(v);
		end
		return r;
	endfunction

	// Flag a value that does not fit 32 bits
	function automatic logic ovf32(input logic signed [63:0] v);
		return (v > 64'sd2147483647) || (v < -64'sd2147483648);
	endfunction

endpackage

### rtl/dfp_inverse_hessian_update.sv
// DFP inverse-Hessian update: matrix store, shared multiplier and divider, sequencer.
`timescale 1ns / 1ps
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid/in_ready, mode, row, col, points,| in
//           | gradients, matrix_value                   |
//  config   | cfg_valid/cfg_ready, dimension_in_use     | in
//  result   | out_valid/out_ready, out_row, out_col,    | out
//           | entry_value, last_entry, status           |
//
// A matrix write or a non-final load is taken while idle. The final load starts a run of
// multiply-accumulate, then n^2 entry updates, each with two divisions on one restoring
// divider (the updates are skipped if a denominator is zero), then n^2 words out, each
// held until taken. The input stays not ready for the whole run.
// Reset loads the identity matrix through per-entry valid bits; no clearing pass.

module dfp_inverse_hessian_update import dfpih_pkg::*; #(
	parameter int DIM = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               mode,
	input  logic [1:0]         row,
	input  logic [1:0]         col,
	input  logic signed [31:0] old_point,
	input  logic signed [31:0] new_point,
	input  logic signed [31:0] old_gradient,
	input  logic signed [31:0] new_gradient,
	input  logic signed [31:0] matrix_value,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         dimension_in_use,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         out_row,
	output logic [1:0]         out_col,
	output logic signed [31:0] entry_value,
	output logic               last_entry,
	output logic [1:0]         status
);

	localparam int IW  = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int AW  = 2 * IW;
	localparam int MD  = 1 << AW;
	localparam int NW  = $clog2(DIM + 1);
	localparam int ACW = 49 + IW;

	// Phases of one entry update
	localparam logic [3:0] P_RD   = 4'd0;
	localparam logic [3:0] P_RD2  = 4'd1;
	localparam logic [3:0] P_MUL1 = 4'd2;
	localparam logic [3:0] P_DV1  = 4'd3;
	localparam logic [3:0] P_IT1  = 4'd4;
	localparam logic [3:0] P_MUL2 = 4'd5;
	localparam logic [3:0] P_DV2  = 4'd6;
	localparam logic [3:0] P_IT2  = 4'd7;
	localparam logic [3:0] P_WR   = 4'd8;

	typedef enum logic [2:0] {S_IDLE, S_HY, S_DEN, S_UPD, S_EMIT} state_t;

	state_t                  st_q;
	logic [3:0]              ph_q;
	logic [IW-1:0]           i_q, j_q, k_q;
	logic                    sel_q;
	logic signed [ACW-1:0]   acc_a_q, acc_b_q;
	logic                    sat_q, zero_q, pend_q;
	logic [2:0]              dim_q;

	// Storage
	logic signed [31:0]      h_mem [MD];
	logic [MD-1:0]           h_vld_q;
	logic signed [31:0]      dx_mem [DIM];
	logic signed [31:0]      y_mem [DIM];
	logic signed [31:0]      hy_mem [DIM];
	logic signed [31:0]      yh_mem [DIM];

	logic signed [31:0]      h_rd_q, dx_rd_q, y_rd_q, hy_rd_q, yh_rd_q, dxa_q, t1_q;
	logic signed [63:0]      prod_q;

	// Divider
	logic [ACW-1:0]          rem_q, dmag_q;
	logic [QW-1:0]           qt_q;
	logic                    dneg_q;
	logic [DCW-1:0]          dcnt_q;

	logic [NW-1:0]           n_use;
	logic [IW-1:0]           last_idx;
	logic [AW-1:0]           h_ra, h_wa;
	logic [IW-1:0]           dx_ra, y_ra;
	logic                    h_we, vec_we, hv_we;
	logic signed [31:0]      h_wd, mul_a, mul_b;
	logic signed [32:0]      dx_w, y_w;
	logic signed [ACW-1:0]   term, acc_b_nx;
	logic signed [ACW-1:0]   dsrc;
	logic [ACW:0]            rem_t;
	logic                    ge;
	logic signed [63:0]      qv;
	logic signed [33:0]      comb_sum;
	logic                    in_acc, row_last, col_last;

	assign cfg_ready = 1'b1;
	assign in_ready  = (st_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;

	// Clamp the dimension in use to 1..DIM
	always_comb begin
		if (dim_q == 3'd0) begin
			n_use = NW'(1);
		end else if (dim_q > DIM) begin
			n_use = NW'(DIM);
		end else begin
			n_use = NW'(dim_q);
		end
	end
	assign last_idx = IW'(n_use - NW'(1));
	assign row_last = (i_q == last_idx);
	assign col_last = (j_q == last_idx);

	// Read addresses
	always_comb begin
		case (st_q)
			S_HY:    h_ra = sel_q ? {k_q, i_q} : {i_q, k_q};
			S_UPD:   h_ra = {i_q, j_q};
			S_EMIT:  h_ra = {i_q, j_q};
			default: h_ra = {i_q, k_q};
		endcase
	end
	assign dx_ra = (st_q == S_UPD && ph_q != P_RD) ? j_q : i_q;
	assign y_ra  = (st_q == S_HY) ? k_q : i_q;

	// Shared multiplier operands
	always_comb begin
		mul_a = h_rd_q;
		mul_b = y_rd_q;
		case (st_q)
			S_DEN: begin
				mul_a = sel_q ? y_rd_q : dx_rd_q;
				mul_b = sel_q ? hy_rd_q : y_rd_q;
			end
			S_UPD: begin
				mul_a = (ph_q == P_MUL2) ? hy_rd_q : dxa_q;
				mul_b = (ph_q == P_MUL2) ? yh_rd_q : dx_rd_q;
			end
			default: begin
				mul_a = h_rd_q;
				mul_b = y_rd_q;
			end
		endcase
	end

	// Scaled product, floor
	assign term     = ACW'(prod_q >>> 16);
	assign acc_b_nx = acc_b_q + term;

	// Divider step and signed quotient
	assign rem_t = {rem_q, qt_q[QW-1]};
	assign ge    = (rem_t >= {1'b0, dmag_q});
	assign qv    = dneg_q ? -$signed({1'b0, qt_q}) : $signed({1'b0, qt_q});
	assign dsrc  = (ph_q == P_DV1) ? acc_a_q : acc_b_q;

	// New entry
	assign comb_sum = 34'(h_rd_q) + 34'(t1_q) - 34'(sat32(qv));

	// Load differences
	assign dx_w = 33'(new_point) - 33'(old_point);
	assign y_w  = 33'(new_gradient) - 33'(old_gradient);

	// Write enables
	assign vec_we = in_acc && (mode == MODE_LOAD) && (row < n_use);
	assign hv_we  = (st_q == S_HY) && (ph_q == P_MUL1) && sel_q && (k_q == last_idx);
	always_comb begin
		if (st_q == S_IDLE) begin
			h_we = in_acc && (mode == MODE_WRITE) && (row < DIM) && (col < DIM);
			h_wa = {IW'(row), IW'(col)};
			h_wd = matrix_value;
		end else begin
			h_we = (st_q == S_UPD) && (ph_q == P_WR);
			h_wa = {i_q, j_q};
			h_wd = sat32(64'(comb_sum));
		end
	end

	// Matrix and vector stores
	always_ff @(posedge clk) begin
		if (h_we) begin
			h_mem[h_wa] <= h_wd;
		end
		if (vec_we) begin
			dx_mem[IW'(row)] <= sat32(64'(dx_w));
			y_mem[IW'(row)]  <= sat32(64'(y_w));
		end
		if (hv_we) begin
			hy_mem[i_q] <= sat32(64'(acc_a_q));
			yh_mem[i_q] <= sat32(64'(acc_b_nx));
		end
		if (h_vld_q[h_ra]) begin
			h_rd_q <= h_mem[h_ra];
		end else begin
			h_rd_q <= (h_ra[AW-1:IW] == h_ra[IW-1:0]) ? ONE_Q : 32'sd0;
		end
		dx_rd_q <= dx_mem[dx_ra];
		y_rd_q  <= y_mem[y_ra];
		hy_rd_q <= hy_mem[i_q];
		yh_rd_q <= yh_mem[j_q];
		prod_q  <= mul_a * mul_b;
	end

	// Hold valid bits; an unwritten entry reads as identity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_vld_q <= '0;
		end else if (h_we) begin
			h_vld_q[h_wa] <= 1'b1;
		end
	end

	// Sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			ph_q        <= P_RD;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			sel_q       <= 1'b0;
			sat_q       <= 1'b0;
			zero_q      <= 1'b0;
			pend_q      <= 1'b0;
			dim_q       <= 3'd4;
			out_valid   <= 1'b0;
			dcnt_q      <= '0;
			acc_a_q     <= '0;
			acc_b_q     <= '0;
			dxa_q       <= '0;
			t1_q        <= '0;
			rem_q       <= '0;
			qt_q        <= '0;
			dmag_q      <= '0;
			dneg_q      <= 1'b0;
			out_row     <= '0;
			out_col     <= '0;
			entry_value <= '0;
			last_entry  <= 1'b0;
			status      <= STAT_OK;
		end else begin
			if (cfg_valid && cfg_ready) begin
				dim_q <= dimension_in_use;
			end
			case (st_q)
				S_IDLE: begin
					if (vec_we) begin
						if (IW'(row) == last_idx) begin
							sat_q  <= pend_q || ovf32(64'(dx_w)) || ovf32(64'(y_w));
							pend_q <= 1'b0;
							zero_q <= 1'b0;
							st_q   <= S_HY;
							ph_q   <= P_RD;
							i_q    <= '0;
							k_q    <= '0;
							sel_q  <= 1'b0;
							acc_a_q <= '0;
							acc_b_q <= '0;
						end else begin
							pend_q <= pend_q || ovf32(64'(dx_w)) || ovf32(64'(y_w));
						end
					end
				end
				// H y and yT H, one product at a time through the read and multiply phases
				S_HY: begin
					if (ph_q != P_MUL1) begin
						ph_q <= ph_q + 4'd1;
					end else begin
						ph_q <= P_RD;
						if (!sel_q) begin
							acc_a_q <= acc_a_q + term;
							sel_q   <= 1'b1;
						end else begin
							sel_q <= 1'b0;
							if (k_q == last_idx) begin
								sat_q   <= sat_q || ovf32(64'(acc_a_q)) || ovf32(64'(acc_b_nx));
								acc_a_q <= '0;
								acc_b_q <= '0;
								k_q     <= '0;
								i_q     <= row_last ? '0 : i_q + IW'(1);
								if (row_last) begin
									st_q <= S_DEN;
								end
							end else begin
								acc_b_q <= acc_b_nx;
								k_q     <= k_q + IW'(1);
							end
						end
					end
				end
				// Denominators dx.y and y.Hy, kept at full accumulator width, not saturated
				S_DEN: begin
					if (ph_q != P_MUL1) begin
						ph_q <= ph_q + 4'd1;
					end else begin
						ph_q <= P_RD;
						if (!sel_q) begin
							acc_a_q <= acc_a_q + term;
							sel_q   <= 1'b1;
						end else begin
							sel_q   <= 1'b0;
							acc_b_q <= acc_b_nx;
							if (row_last) begin
								i_q <= '0;
								j_q <= '0;
								if (acc_a_q == '0 || acc_b_nx == '0) begin
									zero_q <= 1'b1;
									st_q   <= S_EMIT;
								end else begin
									st_q <= S_UPD;
								end
							end else begin
								i_q <= i_q + IW'(1);
							end
						end
					end
				end
				// One entry: two products, two divisions, one combine
				S_UPD: begin
					case (ph_q)
						P_RD, P_RD2, P_MUL1, P_MUL2: begin
							if (ph_q == P_RD2) begin
								dxa_q <= dx_rd_q;
							end
							if (ph_q == P_MUL2) begin
								t1_q  <= sat32(qv);
								sat_q <= sat_q || ovf32(qv);
							end
							ph_q <= ph_q + 4'd1;
						end
						P_DV1, P_DV2: begin
							rem_q  <= '0;
							qt_q   <= prod_q[63] ? QW'(-prod_q) : QW'(prod_q);
							dmag_q <= dsrc[ACW-1] ? ACW'(-dsrc) : ACW'(dsrc);
							dneg_q <= prod_q[63] ^ dsrc[ACW-1];
							dcnt_q <= '0;
							ph_q   <= ph_q + 4'd1;
						end
						P_IT1, P_IT2: begin
							rem_q  <= ge ? ACW'(rem_t - {1'b0, dmag_q}) : ACW'(rem_t);
							qt_q   <= {qt_q[QW-2:0], ge};
							dcnt_q <= dcnt_q + DCW'(1);
							if (dcnt_q == DCW'(QW - 1)) begin
								ph_q <= ph_q + 4'd1;
							end
						end
						P_WR: begin
							sat_q <= sat_q || ovf32(qv) || ovf32(64'(comb_sum));
							ph_q  <= P_RD;
							if (col_last) begin
								j_q <= '0;
								i_q <= row_last ? '0 : i_q + IW'(1);
								if (row_last) begin
									st_q <= S_EMIT;
								end
							end else begin
								j_q <= j_q + IW'(1);
							end
						end
						default: ph_q <= P_RD;
					endcase
				end
				// Stream the block out row by row
				S_EMIT: begin
					case (ph_q)
						P_RD: ph_q <= P_RD2;
						P_RD2: begin
							out_valid   <= 1'b1;
							out_row     <= 2'(i_q);
							out_col     <= 2'(j_q);
							entry_value <= h_rd_q;
							last_entry  <= row_last && col_last;
							status      <= zero_q ? STAT_ZERO : (sat_q ? STAT_SAT : STAT_OK);
							ph_q        <= P_MUL1;
						end
						default: begin
							if (out_ready) begin
								out_valid <= 1'b0;
								ph_q      <= P_RD;
								if (col_last) begin
									j_q <= '0;
									i_q <= row_last ? '0 : i_q + IW'(1);
									if (row_last) begin
										st_q <= S_IDLE;
									end
								end else begin
									j_q <= j_q + IW'(1);
								end
							end
						end
					endcase
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/dfpih_chk.sv
// Port-level checks for the DFP inverse-Hessian update block, with its bind.
`timescale 1ns / 1ps

module dfpih_chk import dfpih_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        last_entry,
	input logic [1:0]  status,
	input logic [31:0] entry_value
);

	// Hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(entry_value) && $stable(status))
		else $error("result word changed while stalled");

	// Take no input while a result word waits
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && in_ready))
		else $error("input ready during result output");

	// Stay busy after a word that is not the last
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_entry |=> !in_ready)
		else $error("run ended before last word");

	// Report only defined status codes
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STAT_OK || status == STAT_ZERO || status == STAT_SAT))
		else $error("undefined status code");

endmodule

bind dfp_inverse_hessian_update dfpih_chk u_dfpih_chk (.*);

### tb/sv/dfpih_checker.sv
// Checker for the DFP inverse-Hessian update block: watches all channels, predicts and compares.
`timescale 1ns / 1ps

module dfpih_checker import dfpih_pkg::*; #(
	parameter int DIM = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               mode,
	input  logic [1:0]         row,
	input  logic [1:0]         col,
	input  logic signed [31:0] old_point,
	input  logic signed [31:0] new_point,
	input  logic signed [31:0] old_gradient,
	input  logic signed [31:0] new_gradient,
	input  logic signed [31:0] matrix_value,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         dimension_in_use,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [1:0]         out_row,
	input  logic [1:0]         out_col,
	input  logic signed [31:0] entry_value,
	input  logic               last_entry,
	input  logic [1:0]         status,
	output int                 pending,
	output int                 errors
);

	typedef struct {
		logic [1:0]         r;
		logic [1:0]         c;
		logic signed [31:0] value;
		logic               last;
		logic [1:0]         stat;
	} entry_word_t;

	entry_word_t entry_q[$];

	// Model copy of the matrix, the step and gradient-change vectors and the register
	longint   hess [DIM*DIM];
	longint   step [DIM];
	longint   gchg [DIM];
	bit       load_sat;
	logic [2:0] dim_reg;

	function automatic longint clip32(input longint v, inout bit flag);
		if (v > 64'sd2147483647) begin
			flag = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			flag = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// Q16.16 product, scaled back with floor
	function automatic longint qmul(input longint a, input longint b);
		return (a * b) >>> 16;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
		errors = errors + 1;
	endtask

	// Apply one accepted input word and queue the entries of any update run
	task automatic predict_update();
		int          n, i, j, k;
		longint      hy [DIM];
		longint      yh [DIM];
		longint      nxt [DIM*DIM];
		longint      a, b, d1, d2, t1, t2;
		bit          sat;
		logic [1:0]  st;
		entry_word_t w;
		n = (dim_reg < 1) ? 1 : ((dim_reg > DIM) ? DIM : int'(dim_reg));
		if (mode == MODE_WRITE) begin
			hess[row*DIM + col] = longint'(matrix_value);
			return;
		end
		if (row >= n) return;
		step[row] = clip32(longint'(new_point) - longint'(old_point), load_sat);
		gchg[row] = clip32(longint'(new_gradient) - longint'(old_gradient), load_sat);
		if (row != n - 1) return;
		sat = load_sat;
		load_sat = 1'b0;
		d1 = 0;
		d2 = 0;
		for (i = 0; i < n; i++) begin
			a = 0;
			b = 0;
			for (k = 0; k < n; k++) begin
				a += qmul(hess[i*DIM + k], gchg[k]);
				b += qmul(gchg[k], hess[k*DIM + i]);
			end
			hy[i] = clip32(a, sat);
			yh[i] = clip32(b, sat);
		end
		for (i = 0; i < n; i++) begin
			d1 += qmul(step[i], gchg[i]);
			d2 += qmul(gchg[i], hy[i]);
		end
		if (d1 == 0 || d2 == 0) begin
			st = STAT_ZERO;
		end else begin
			for (i = 0; i < n; i++)
				for (j = 0; j < n; j++) begin
					t1 = clip32((step[i] * step[j]) / d1, sat);
					t2 = clip32((hy[i] * yh[j]) / d2, sat);
					nxt[i*DIM + j] = clip32(hess[i*DIM + j] + t1 - t2, sat);
				end
			for (i = 0; i < n; i++)
				for (j = 0; j < n; j++)
					hess[i*DIM + j] = nxt[i*DIM + j];
			st = sat ? STAT_SAT : STAT_OK;
		end
		for (i = 0; i < n; i++)
			for (j = 0; j < n; j++) begin
				w.r     = 2'(i);
				w.c     = 2'(j);
				w.value = 32'(hess[i*DIM + j]);
				w.last  = (i == n - 1) && (j == n - 1);
				w.stat  = st;
				entry_q.push_back(w);
			end
	endtask

	// Track the channels at each edge
	always @(posedge clk or negedge arst_n) begin
		entry_word_t w;
		if (!arst_n) begin
			for (int i = 0; i < DIM*DIM; i++) hess[i] = 0;
			for (int i = 0; i < DIM; i++) begin
				hess[i*DIM + i] = 65536;
				step[i] = 0;
				gchg[i] = 0;
			end
			load_sat = 1'b0;
			dim_reg  = 3'd4;
			entry_q.delete();
			errors   = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) dim_reg = dimension_in_use;
			if (in_valid && in_ready) predict_update();
			if (out_valid && out_ready) begin
				if (entry_q.size() == 0) begin
					report_mismatch("unexpected word, entry", entry_value, 0);
				end else begin
					w = entry_q.pop_front();
					if (out_row !== w.r) report_mismatch("out_row", out_row, w.r);
					if (out_col !== w.c) report_mismatch("out_col", out_col, w.c);
					if (entry_value !== w.value)
						report_mismatch("entry_value", entry_value, w.value);
					if (last_entry !== w.last)
						report_mismatch("last_entry", last_entry, w.last);
					if (status !== w.stat) report_mismatch("status", status, w.stat);
				end
			end
			pending <= entry_q.size();
		end
	end

endmodule

### tb/sv/tb.sv
// Testbench top for the DFP inverse-Hessian update block: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb import dfpih_pkg::*;;

	localparam int WATCH_LIMIT = 20000;
	localparam int HOLD_CYCLES = 3000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               mode;
	logic [1:0]         row;
	logic [1:0]         col;
	logic signed [31:0] old_point;
	logic signed [31:0] new_point;
	logic signed [31:0] old_gradient;
	logic signed [31:0] new_gradient;
	logic signed [31:0] matrix_value;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         dimension_in_use;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         out_row;
	logic [1:0]         out_col;
	logic signed [31:0] entry_value;
	logic               last_entry;
	logic [1:0]         status;
	int                 pending;
	int                 errors;

	int send_idle = 0;
	int recv_idle = 0;
	int hold_req  = 0;
	int dim_now   = 4;

	always #5 clk = ~clk;

	dfp_inverse_hessian_update #(.DIM(4)) dut (.*);
	dfpih_checker #(.DIM(4)) chk (.*);

	// Receiver: random stalls, plus a long hold-off on request
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle);
			end
		end
	end

	// Watchdog on cycles with no word accepted on any channel
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCH_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	function automatic logic signed [31:0] rand_q();
		case ($urandom_range(0, 9))
			0, 1: return $urandom;
			2: return 32'sd0;
			default: return $signed($urandom_range(0, 32'h7_FFFF)) - 32'sh4_0000;
		endcase
	endfunction

	// Offer one word and hold it until accepted
	task automatic send_word(input logic m, input logic [1:0] r, input logic [1:0] c,
		input logic signed [31:0] op, input logic signed [31:0] np,
		input logic signed [31:0] og, input logic signed [31:0] ng,
		input logic signed [31:0] mv);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= m;
		row          <= r;
		col          <= c;
		old_point    <= op;
		new_point    <= np;
		old_gradient <= og;
		new_gradient <= ng;
		matrix_value <= mv;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_load(input logic [1:0] r, input logic signed [31:0] op,
		input logic signed [31:0] np, input logic signed [31:0] og,
		input logic signed [31:0] ng);
		send_word(MODE_LOAD, r, 2'($urandom), op, np, og, ng, $urandom);
	endtask

	task automatic send_matrix(input logic [1:0] r, input logic [1:0] c,
		input logic signed [31:0] v);
		send_word(MODE_WRITE, r, c, $urandom, $urandom, $urandom, $urandom, v);
	endtask

	// Hold the input until every expected word is out and the block is quiet
	task automatic wait_drained();
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_dim(input logic [2:0] v);
		wait_drained();
		cfg_valid        <= 1'b1;
		dimension_in_use <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		dim_now = (v < 1) ? 1 : ((v > 4) ? 4 : int'(v));
	endtask

	// Random words: mostly full load sequences, some matrix writes and stray loads
	task automatic run_phase(input int count);
		int sent;
		sent = 0;
		while (sent < count) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					send_matrix(2'($urandom), 2'($urandom), rand_q());
					sent++;
				end
				2: begin
					send_load(2'($urandom), rand_q(), rand_q(), rand_q(), rand_q());
					sent++;
				end
				default: begin
					for (int i = 0; i < dim_now; i++)
						send_load(2'(i), rand_q(), rand_q(), rand_q(), rand_q());
					sent += dim_now;
				end
			endcase
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		in_valid         = 1'b0;
		mode             = MODE_LOAD;
		row              = '0;
		col              = '0;
		old_point        = '0;
		new_point        = '0;
		old_gradient     = '0;
		new_gradient     = '0;
		matrix_value     = '0;
		cfg_valid        = 1'b0;
		dimension_in_use = 3'd4;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: load every element once so no update reads an unloaded one
		send_load(2'd0, 32'sd0, ONE_Q, 32'sd0, ONE_Q);
		send_load(2'd1, 32'sd0, ONE_Q, ONE_Q, 32'sd0);
		send_load(2'd2, ONE_Q, 32'sd0, 32'sd0, -ONE_Q);
		send_load(2'd3, 32'sd0, 32'sh0002_0000, 32'sd0, ONE_Q);
		write_dim(3'd1);
		// Zero step, zero gradient change, then a normal step
		send_load(2'd0, ONE_Q, ONE_Q, 32'sd0, ONE_Q);
		send_load(2'd0, ONE_Q, 32'sd0, ONE_Q, ONE_Q);
		send_load(2'd0, 32'sd0, ONE_Q, 32'sd0, 32'sh0002_0000);
		// Saturating differences at the field extremes
		send_load(2'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
		// Load beyond the block in use, write outside it, extreme matrix values
		send_load(2'd2, ONE_Q, 32'sd0, ONE_Q, 32'sd0);
		send_matrix(2'd3, 2'd3, 32'sh7FFF_FFFF);
		send_matrix(2'd0, 2'd0, 32'sh8000_0000);
		send_load(2'd0, 32'sd0, 32'sh7FFF_FFFF, 32'sd0, 32'sh7FFF_FFFF);
		send_matrix(2'd0, 2'd0, ONE_Q);
		write_dim(3'd0);
		send_load(2'd0, 32'sd0, ONE_Q, 32'sd0, ONE_Q);
		write_dim(3'd7);
		send_matrix(2'd3, 2'd3, ONE_Q);
		for (int i = 0; i < 4; i++)
			send_load(2'(i), 32'sd0, ONE_Q, 32'sd0, ONE_Q);

		// Random phases with shifting idle rates and block sizes
		write_dim(3'd2);
		send_idle = 22;
		recv_idle = 74;
		run_phase(87);
		write_dim(3'd3);
		send_idle = 74;
		recv_idle = 22;
		run_phase(43);
		wait_drained();
		run_phase(44);
		write_dim(3'd4);
		send_idle = 0;
		recv_idle = 0;
		hold_req <= hold_req + 1;
		run_phase(86);

		wait_drained();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### dfp_inverse_hessian_update.f
rtl/dfpih_pkg.sv
rtl/dfp_inverse_hessian_update.sv
rtl/dfpih_chk.sv
tb/sv/dfpih_checker.sv
tb/sv/tb.sv
